// ===== rtl/core/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants for the traffic light sequencer
// Event codes, mode codes, lamp bits and the sequencer state record.
// ----------------------------------------------------------------------------
package tls_pkg;

  // event kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MODE = 2'd1,
    FUNC_PED  = 2'd2,
    FUNC_RATE = 2'd3
  } func_t;

  // mode codes
  localparam logic [1:0] MODE_CYCLE   = 2'd0;
  localparam logic [1:0] MODE_BLINK_R = 2'd1;
  localparam logic [1:0] MODE_BLINK_Y = 2'd2;

  // sequencing constants
  localparam logic [2:0] STOP_TICKS = 3'd5;
  localparam logic [2:0] CYCLE_LAST = 3'd5;
  localparam logic [2:0] STOP_PHASE = 3'd4;
  localparam logic [2:0] GREEN_LAST = 3'd2;
  localparam logic [2:0] YELLOW_PH  = 3'd3;
  localparam logic [3:0] RATE_MIN   = 4'd1;
  localparam logic [3:0] RATE_MAX   = 4'd9;
  localparam logic [3:0] RATE_RESET = 4'd1;

  // lamp drive bits: red, yellow, green
  localparam logic [2:0] LAMP_R = 3'b100;
  localparam logic [2:0] LAMP_Y = 3'b010;
  localparam logic [2:0] LAMP_G = 3'b001;
  localparam logic [2:0] LAMP_OFF = 3'b000;

  // one input event
  typedef struct packed {
    func_t      func;
    logic       mode_lvl;
    logic       ped_lvl;
    logic [3:0] rate;
  } event_t;

  // sequencer state
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] rate;
    logic [2:0] phase;
    logic       ped_request;
    logic       stop_active;
    logic [2:0] stop_count;
    logic       lamp_test;
    logic [2:0] lamps;
  } state_t;

  // reset value of everything but the lamp drives
  function automatic state_t clear_state(input logic [2:0] lamps);
    state_t s;
    s.mode        = MODE_CYCLE;
    s.rate        = RATE_RESET;
    s.phase       = 3'd0;
    s.ped_request = 1'b0;
    s.stop_active = 1'b0;
    s.stop_count  = 3'd0;
    s.lamp_test   = 1'b0;
    s.lamps       = lamps;
    return s;
  endfunction

endpackage

// ===== rtl/core/traffic_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// traffic_light_sequencer: traffic light controller with pedestrian request
// Input register, one pass of next-state logic, output register.
// ----------------------------------------------------------------------------
// throughput: one event per cycle while the output is not stalled, set by the single-pass state update
// reset: rst clears state to normal mode, rate 1, lamps off, no pending results
// ----------------------------------------------------------------------------
module traffic_light_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: [0] mode_button_level, [1] ped_button_level, [5:2] rate_value
  input  logic [7:0]  s_tdata,
  // tuser: [1:0] func
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: [0] red lamp, [1] yellow lamp, [2] green lamp, [4:3] mode_now,
  //        [8:5] rate_now, [9] ped_pending, [10] ped_stop_on, [11] lamp_test_on
  output logic [15:0] m_tdata
);

  logic            in_valid;
  tls_pkg::event_t in_event;
  tls_pkg::state_t state;
  tls_pkg::state_t state_next;
  logic            advance;

  // an event moves on when the output register is free or drains
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_event.func     <= tls_pkg::func_t'(s_tuser);
      in_event.mode_lvl <= s_tdata[0];
      in_event.ped_lvl  <= s_tdata[1];
      in_event.rate     <= s_tdata[5:2];
    end
  end

  // next-state logic
  tls_update u_update (
    .ev  (in_event),
    .cur (state),
    .nxt (state_next)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tls_pkg::clear_state(tls_pkg::LAMP_OFF);
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {4'd0, state_next.lamp_test, state_next.stop_active,
                  state_next.ped_request, state_next.rate, state_next.mode,
                  state_next.lamps[0], state_next.lamps[1], state_next.lamps[2]};
    end
  end

endmodule

// ===== rtl/core/tls_update.sv =====
// ----------------------------------------------------------------------------
// tls_update: next-state logic of the traffic light sequencer
// Applies one event to the current state and recomputes lamps on ticks.
// ----------------------------------------------------------------------------
module tls_update (
  input  tls_pkg::event_t ev,
  input  tls_pkg::state_t cur,
  output tls_pkg::state_t nxt
);

  tls_pkg::state_t s_test;
  tls_pkg::state_t s_tick;
  logic [2:0]      cnt_inc;
  logic [2:0]      phase_inc;
  logic [2:0]      lamps_new;

  // lamp test handling, then stop count or phase advance
  always_comb begin
    s_test = cur;
    if (ev.mode_lvl && ev.ped_lvl) begin
      s_test.lamp_test = 1'b1;
    end else if (!ev.mode_lvl && !ev.ped_lvl && cur.lamp_test) begin
      s_test = tls_pkg::clear_state(cur.lamps);
    end
    cnt_inc   = s_test.stop_count + 3'd1;
    phase_inc = (s_test.phase >= tls_pkg::CYCLE_LAST) ? 3'd0 : s_test.phase + 3'd1;
    s_tick    = s_test;
    if (s_test.stop_active) begin
      if (cnt_inc >= tls_pkg::STOP_TICKS) begin
        s_tick.stop_active = 1'b0;
        s_tick.stop_count  = 3'd0;
        s_tick.ped_request = 1'b0;
      end else begin
        s_tick.stop_count = cnt_inc;
      end
    end else begin
      s_tick.phase = phase_inc;
      if (s_test.ped_request && s_test.mode == tls_pkg::MODE_CYCLE &&
          !s_test.lamp_test && phase_inc == tls_pkg::STOP_PHASE) begin
        s_tick.stop_active = 1'b1;
        s_tick.stop_count  = 3'd0;
      end
    end
  end

  // lamp drives from the post-tick state
  always_comb begin
    lamps_new = tls_pkg::LAMP_OFF;
    if (s_tick.lamp_test) begin
      lamps_new = tls_pkg::LAMP_R | tls_pkg::LAMP_Y | tls_pkg::LAMP_G;
    end else if (s_tick.stop_active) begin
      lamps_new = tls_pkg::LAMP_R | tls_pkg::LAMP_Y;
    end else begin
      unique case (s_tick.mode)
        tls_pkg::MODE_CYCLE: begin
          if (s_tick.phase <= tls_pkg::GREEN_LAST) lamps_new = tls_pkg::LAMP_G;
          else if (s_tick.phase == tls_pkg::YELLOW_PH) lamps_new = tls_pkg::LAMP_Y;
          else lamps_new = tls_pkg::LAMP_R;
        end
        tls_pkg::MODE_BLINK_R: begin
          lamps_new = s_tick.phase[0] ? tls_pkg::LAMP_R : tls_pkg::LAMP_OFF;
        end
        tls_pkg::MODE_BLINK_Y: begin
          lamps_new = s_tick.phase[0] ? tls_pkg::LAMP_Y : tls_pkg::LAMP_OFF;
        end
        default: begin
          lamps_new = tls_pkg::LAMP_OFF;
        end
      endcase
    end
  end

  // event dispatch
  always_comb begin
    nxt = cur;
    unique case (ev.func)
      tls_pkg::FUNC_TICK: begin
        nxt       = s_tick;
        nxt.lamps = lamps_new;
      end
      tls_pkg::FUNC_MODE: begin
        nxt.phase = 3'd0;
        if (cur.mode == tls_pkg::MODE_CYCLE) nxt.mode = tls_pkg::MODE_BLINK_R;
        else if (cur.mode == tls_pkg::MODE_BLINK_R) nxt.mode = tls_pkg::MODE_BLINK_Y;
        else nxt.mode = tls_pkg::MODE_CYCLE;
      end
      tls_pkg::FUNC_PED: begin
        if (cur.mode == tls_pkg::MODE_CYCLE && !cur.stop_active && !cur.lamp_test) begin
          nxt.ped_request = 1'b1;
        end
      end
      tls_pkg::FUNC_RATE: begin
        if (ev.rate >= tls_pkg::RATE_MIN && ev.rate <= tls_pkg::RATE_MAX) begin
          nxt.rate = ev.rate;
        end
      end
    endcase
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the traffic light sequencer
// Drives tick, mode, pedestrian and rate events over the input stream and
// tracks the lamp controller state in a local model. Every output transaction
// is compared field by field against the oldest predicted status. Handshake
// pressure changes between phases: no idling, sparse input, a slow consumer,
// and both at once.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_ITEMS  = 312;
  localparam int SETTLE       = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // predicted status after one event
  typedef struct {
    logic       red;
    logic       yellow;
    logic       green;
    logic [1:0] mode;
    logic [3:0] rate;
    logic       ped;
    logic       stop;
    logic       ltest;
  } light_status_t;

  // lamp controller model plus queue of predicted status words
  class light_scoreboard;
    logic [1:0] mode;
    logic [3:0] rate;
    logic [2:0] phase;
    logic       ped_req;
    logic       stop_on;
    logic [2:0] stop_cnt;
    logic       ltest;
    logic [2:0] lamps;
    light_status_t status_q[$];
    int unsigned errors;
    int unsigned events;
    int unsigned stops;
    int unsigned lamp_tests;

    function new();
      clear_all();
      lamps = tls_pkg::LAMP_OFF;
    endfunction

    // everything but the lamp drives back to power-up values
    function void clear_all();
      mode     = tls_pkg::MODE_CYCLE;
      rate     = tls_pkg::RATE_RESET;
      phase    = 3'd0;
      ped_req  = 1'b0;
      stop_on  = 1'b0;
      stop_cnt = 3'd0;
      ltest    = 1'b0;
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // apply one accepted event and queue the status it yields
    function void note_event(tls_pkg::func_t f, logic mlev, logic plev, logic [3:0] rv);
      light_status_t s;
      events++;
      case (f)
        tls_pkg::FUNC_TICK: begin
          if (mlev && plev) begin
            if (!ltest) lamp_tests++;
            ltest = 1'b1;
          end else if (!mlev && !plev && ltest) begin
            clear_all();
          end
          if (stop_on) begin
            stop_cnt = stop_cnt + 3'd1;
            if (stop_cnt >= tls_pkg::STOP_TICKS) begin
              stop_on  = 1'b0;
              stop_cnt = 3'd0;
              ped_req  = 1'b0;
            end
          end else begin
            phase = (phase >= tls_pkg::CYCLE_LAST) ? 3'd0 : phase + 3'd1;
            if (ped_req && mode == tls_pkg::MODE_CYCLE && !ltest &&
                phase == tls_pkg::STOP_PHASE) begin
              stop_on  = 1'b1;
              stop_cnt = 3'd0;
              stops++;
            end
          end
          // lamp priority: test, then pedestrian stop, then mode pattern
          if (ltest) begin
            lamps = tls_pkg::LAMP_R | tls_pkg::LAMP_Y | tls_pkg::LAMP_G;
          end else if (stop_on) begin
            lamps = tls_pkg::LAMP_R | tls_pkg::LAMP_Y;
          end else begin
            case (mode)
              tls_pkg::MODE_CYCLE: begin
                if (phase <= tls_pkg::GREEN_LAST) lamps = tls_pkg::LAMP_G;
                else if (phase == tls_pkg::YELLOW_PH) lamps = tls_pkg::LAMP_Y;
                else lamps = tls_pkg::LAMP_R;
              end
              tls_pkg::MODE_BLINK_R: lamps = phase[0] ? tls_pkg::LAMP_R : tls_pkg::LAMP_OFF;
              tls_pkg::MODE_BLINK_Y: lamps = phase[0] ? tls_pkg::LAMP_Y : tls_pkg::LAMP_OFF;
              default:               lamps = tls_pkg::LAMP_OFF;
            endcase
          end
        end
        tls_pkg::FUNC_MODE: begin
          phase = 3'd0;
          if (mode == tls_pkg::MODE_CYCLE) mode = tls_pkg::MODE_BLINK_R;
          else if (mode == tls_pkg::MODE_BLINK_R) mode = tls_pkg::MODE_BLINK_Y;
          else mode = tls_pkg::MODE_CYCLE;
        end
        tls_pkg::FUNC_PED: begin
          if (mode == tls_pkg::MODE_CYCLE && !stop_on && !ltest) ped_req = 1'b1;
        end
        default: begin
          if (rv >= tls_pkg::RATE_MIN && rv <= tls_pkg::RATE_MAX) rate = rv;
        end
      endcase
      s.red    = |(lamps & tls_pkg::LAMP_R);
      s.yellow = |(lamps & tls_pkg::LAMP_Y);
      s.green  = |(lamps & tls_pkg::LAMP_G);
      s.mode   = mode;
      s.rate   = rate;
      s.ped    = ped_req;
      s.stop   = stop_on;
      s.ltest  = ltest;
      status_q.push_back(s);
    endfunction

    function void compare(string field, logic [3:0] exp_v, logic [3:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    // check one output transaction against the oldest prediction
    function void check_result(logic [15:0] d);
      light_status_t s;
      if (status_q.size() == 0) begin
        $error("status word 0x%04h arrived with nothing predicted", d);
        errors++;
        return;
      end
      s = status_q.pop_front();
      compare("red_lamp",     {3'd0, s.red},    {3'd0, d[0]});
      compare("yellow_lamp",  {3'd0, s.yellow}, {3'd0, d[1]});
      compare("green_lamp",   {3'd0, s.green},  {3'd0, d[2]});
      compare("mode_now",     {2'd0, s.mode},   {2'd0, d[4:3]});
      compare("rate_now",     s.rate,           d[8:5]);
      compare("ped_pending",  {3'd0, s.ped},    {3'd0, d[9]});
      compare("ped_stop_on",  {3'd0, s.stop},   {3'd0, d[10]});
      compare("lamp_test_on", {3'd0, s.ltest},  {3'd0, d[11]});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  int unsigned cycles     = 0;

  light_scoreboard book = new();

  traffic_light_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: random stalls, check each accepted transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // one event transaction, with random idle cycles ahead of it
  task automatic send_event(input tls_pkg::func_t f, input logic mlev, input logic plev,
                            input logic [3:0] rv);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {2'b00, rv, plev, mlev};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_event(f, mlev, plev, rv);
  endtask

  // hold the input off until every predicted status has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned    r;
    int unsigned    lv;
    logic           ml;
    logic           pl;
    logic [3:0]     rv;
    tls_pkg::func_t f;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rate limits, pedestrian stop, mode press during stop,
    // flash modes, lamp test start and end
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_RATE, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_RATE, 1'b1, 1'b1, 4'd15);
    send_event(tls_pkg::FUNC_RATE, 1'b0, 1'b0, 4'd9);
    send_event(tls_pkg::FUNC_RATE, 1'b0, 1'b0, 4'd1);
    send_event(tls_pkg::FUNC_RATE, 1'b0, 1'b0, 4'd10);
    send_event(tls_pkg::FUNC_PED,  1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b1, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b1, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_PED,  1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_MODE, 1'b0, 1'b0, 4'd0);
    repeat (5) send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_MODE, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_PED,  1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b1, 1'b1, 4'd15);
    send_event(tls_pkg::FUNC_TICK, 1'b1, 1'b1, 4'd0);
    send_event(tls_pkg::FUNC_TICK, 1'b0, 1'b0, 4'd0);
    drain();

    // random events under four handshake pressure settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 82; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      repeat (PHASE_ITEMS) begin
        r  = $urandom_range(99);
        lv = $urandom_range(99);
        rv = 4'($urandom_range(15));
        ml = 1'b0;
        pl = 1'b0;
        // mostly quiet ticks, rare lamp test and single-button levels
        if (lv >= 96) {ml, pl} = 2'($urandom_range(1, 2));
        else if (lv >= 92) {ml, pl} = 2'b11;
        if (r < 72) f = tls_pkg::FUNC_TICK;
        else if (r < 84) f = tls_pkg::FUNC_PED;
        else if (r < 89) f = tls_pkg::FUNC_MODE;
        else f = tls_pkg::FUNC_RATE;
        send_event(f, ml, pl, rv);
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (book.pending() != 0) begin
      $error("%0d predicted status words never arrived", book.pending());
      book.errors++;
    end
    $display("ran %0d events through four handshake settings", book.events);
    $display("saw %0d pedestrian stops and %0d lamp test entries",
             book.stops, book.lamp_tests);
    if (book.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
